// ===== hdl/apool_pkg.sv =====
// Shared constants, register codes and transaction types for the average pooling unit.
package apool_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int COORD_BITS       = 10;
  localparam int CHAN_BITS        = 4;
  localparam int HEIGHT_LIMIT     = 1024;
  localparam int RECIP_FRAC       = 16;
  localparam int QUEUE_DEPTH      = 4;

  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_CHANNELS = 16;
  localparam int DEF_MAX_WINDOW   = 8;

  localparam int CFG_INDEX_BITS   = 3;
  localparam int CFG_DATA_BITS    = 17;

  localparam int WIDTH_BITS       = 11;
  localparam int HEIGHT_BITS      = 11;
  localparam int CHANS_BITS       = 5;
  localparam int WIN_BITS         = 4;
  localparam int RECIP_BITS       = 17;

  localparam logic [WIDTH_BITS-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [HEIGHT_BITS-1:0] RST_IMAGE_HEIGHT = 11'd1024;
  localparam logic [CHANS_BITS-1:0]  RST_CHANNELS     = 5'd1;
  localparam logic [WIN_BITS-1:0]    RST_WIN_H        = 4'd2;
  localparam logic [WIN_BITS-1:0]    RST_WIN_W        = 4'd2;
  localparam logic [RECIP_BITS-1:0]  RST_RECIP        = 17'd16384;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_IMAGE_WIDTH     = 3'd0,
    CFG_IMAGE_HEIGHT    = 3'd1,
    CFG_CHANNEL_COUNT   = 3'd2,
    CFG_WINDOW_HEIGHT   = 3'd3,
    CFG_WINDOW_WIDTH    = 3'd4,
    CFG_AREA_RECIPROCAL = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic [WIDTH_BITS-1:0]  width;
    logic [HEIGHT_BITS-1:0] height;
    logic [CHANS_BITS-1:0]  chans;
    logic [WIN_BITS-1:0]    win_h;
    logic [WIN_BITS-1:0]    win_w;
    logic [RECIP_BITS-1:0]  recip;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first;
    logic                          emit;
    logic                          last;
    logic [COORD_BITS-1:0]         out_row;
    logic [COORD_BITS-1:0]         out_col;
    logic [CHAN_BITS-1:0]          chan;
  } item_meta_t;

endpackage

// ===== hdl/apool_if.sv =====
// Valid/ready channel interfaces for input samples and pooled results.
interface apool_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [apool_pkg::SAMPLE_BITS-1:0] sample;
  logic                                    frame_start;

  modport source (output valid, output sample, output frame_start, input ready);
  modport sink (input valid, input sample, input frame_start, output ready);
endinterface

interface apool_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [apool_pkg::SAMPLE_BITS-1:0] average;
  logic [apool_pkg::COORD_BITS-1:0]         out_row;
  logic [apool_pkg::COORD_BITS-1:0]         out_column;
  logic [apool_pkg::CHAN_BITS-1:0]          channel;
  logic                                    frame_end;

  modport source (
    output valid, output average, output out_row, output out_column,
    output channel, output frame_end, input ready
  );
  modport sink (
    input valid, input average, input out_row, input out_column,
    input channel, input frame_end, output ready
  );
endinterface

// ===== hdl/apool_front.sv =====
// Front end: tracks raster position, classifies each sample and builds store requests.
module apool_front #(
  parameter int MAX_WIDTH    = apool_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = apool_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_WINDOW   = apool_pkg::DEF_MAX_WINDOW,
  parameter int AW           = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  apool_pkg::cfg_t        cfg_i,
  apool_in_if.sink               pix_in,
  input  logic                   q_full_i,
  output logic                   push_o,
  output logic [AW-1:0]          idx_o,
  output apool_pkg::item_meta_t  meta_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int WW  = $clog2(MAX_WINDOW);
  localparam int RW  = $clog2(apool_pkg::HEIGHT_LIMIT);
  localparam int XW  = (CW + 6 > 12) ? CW + 6 : 12;
  localparam int YW  = RW + 6;
  localparam int NW  = (CHW > 5) ? CHW + 1 : 6;

  logic [CHW-1:0] ch_q, ch_d, ch_c;
  logic [CW-1:0]  cp_q, cp_d, cp_c;
  logic [CW-1:0]  occ_q, occ_d, occ_c;
  logic [WW-1:0]  ciw_q, ciw_d, ciw_c;
  logic [RW-1:0]  rp_q, rp_d, rp_c;
  logic [RW-1:0]  orc_q, orc_d, orc_c;
  logic [WW-1:0]  riw_q, riw_d, riw_c;

  logic          accept;
  logic [XW-1:0] col_end, col_over, cp_inc;
  logic [YW-1:0] row_end, row_over, rp_inc;
  logic          col_ok, col_last, row_ok, row_last;
  logic [NW-1:0] ch_inc;
  logic [4:0]    ciw_inc, riw_inc;
  logic          ch_wrap, cp_wrap, ciw_wrap, rp_wrap, riw_wrap;
  logic          emit;

  assign pix_in.ready = !q_full_i;
  assign accept       = pix_in.valid && pix_in.ready;

  assign ch_c  = pix_in.frame_start ? '0 : ch_q;
  assign cp_c  = pix_in.frame_start ? '0 : cp_q;
  assign occ_c = pix_in.frame_start ? '0 : occ_q;
  assign ciw_c = pix_in.frame_start ? '0 : ciw_q;
  assign rp_c  = pix_in.frame_start ? '0 : rp_q;
  assign orc_c = pix_in.frame_start ? '0 : orc_q;
  assign riw_c = pix_in.frame_start ? '0 : riw_q;

  assign col_end  = (XW'(occ_c) + XW'(1)) * XW'(cfg_i.win_w);
  assign col_over = col_end + XW'(cfg_i.win_w);
  assign col_ok   = col_end <= XW'(cfg_i.width);
  assign col_last = col_over > XW'(cfg_i.width);
  assign row_end  = (YW'(orc_c) + YW'(1)) * YW'(cfg_i.win_h);
  assign row_over = row_end + YW'(cfg_i.win_h);
  assign row_ok   = row_end <= YW'(cfg_i.height);
  assign row_last = row_over > YW'(cfg_i.height);

  assign ch_inc   = NW'(ch_c) + NW'(1);
  assign ch_wrap  = ch_inc >= NW'(cfg_i.chans);
  assign cp_inc   = XW'(cp_c) + XW'(1);
  assign cp_wrap  = cp_inc >= XW'(cfg_i.width);
  assign ciw_inc  = 5'(ciw_c) + 5'd1;
  assign ciw_wrap = ciw_inc >= 5'(cfg_i.win_w);
  assign rp_inc   = YW'(rp_c) + YW'(1);
  assign rp_wrap  = rp_inc >= YW'(cfg_i.height);
  assign riw_inc  = 5'(riw_c) + 5'd1;
  assign riw_wrap = riw_inc >= 5'(cfg_i.win_h);

  assign emit = (riw_inc == 5'(cfg_i.win_h)) && (ciw_inc == 5'(cfg_i.win_w));

  assign push_o = accept && col_ok && row_ok;
  assign idx_o  = AW'(occ_c) * AW'(MAX_CHANNELS) + AW'(ch_c);

  always_comb begin
    meta_o.sample  = pix_in.sample;
    meta_o.first   = (riw_c == '0) && (ciw_c == '0);
    meta_o.emit    = emit;
    meta_o.last    = row_last && col_last && (ch_inc == NW'(cfg_i.chans));
    meta_o.out_row = apool_pkg::COORD_BITS'(orc_c);
    meta_o.out_col = apool_pkg::COORD_BITS'(occ_c);
    meta_o.chan    = apool_pkg::CHAN_BITS'(ch_c);
  end

  always_comb begin
    ch_d  = ch_c;
    cp_d  = cp_c;
    occ_d = occ_c;
    ciw_d = ciw_c;
    rp_d  = rp_c;
    orc_d = orc_c;
    riw_d = riw_c;
    if (ch_wrap) begin
      ch_d  = '0;
      cp_d  = CW'(cp_inc);
      ciw_d = ciw_wrap ? '0 : WW'(ciw_inc);
      occ_d = ciw_wrap ? occ_c + CW'(1) : occ_c;
      if (cp_wrap) begin
        cp_d  = '0;
        ciw_d = '0;
        occ_d = '0;
        rp_d  = RW'(rp_inc);
        riw_d = riw_wrap ? '0 : WW'(riw_inc);
        orc_d = riw_wrap ? orc_c + RW'(1) : orc_c;
        if (rp_wrap) begin
          rp_d  = '0;
          riw_d = '0;
          orc_d = '0;
        end
      end
    end else begin
      ch_d = CHW'(ch_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q  <= '0;
      cp_q  <= '0;
      occ_q <= '0;
      ciw_q <= '0;
      rp_q  <= '0;
      orc_q <= '0;
      riw_q <= '0;
    end else if (accept) begin
      ch_q  <= ch_d;
      cp_q  <= cp_d;
      occ_q <= occ_d;
      ciw_q <= ciw_d;
      rp_q  <= rp_d;
      orc_q <= orc_d;
      riw_q <= riw_d;
    end
  end

endmodule

// ===== hdl/apool_fifo.sv =====
// Short register queue that decouples the front end from the accumulate pipeline.
module apool_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = apool_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] head_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] data_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]     count_q;
  logic              do_push, do_pop;

  assign full_o  = count_q == NW'(DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = data_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + NW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

endmodule

// ===== hdl/apool_back.sv =====
// Back end: partial sum store read-modify-write, scaling, rounding, saturation and result register.
module apool_back #(
  parameter int AW       = 14,
  parameter int DEPTH    = 16384,
  parameter int SUM_BITS = 22
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [apool_pkg::RECIP_BITS-1:0]     recip_i,
  input  logic                                 q_valid_i,
  input  logic [AW-1:0]                        q_idx_i,
  input  apool_pkg::item_meta_t                q_meta_i,
  output logic                                 q_pop_o,
  apool_out_if.source                          avg_out
);

  localparam int PROD_BITS = SUM_BITS + apool_pkg::RECIP_BITS + 1;
  localparam int RB        = PROD_BITS + 1;
  localparam logic signed [RB-1:0] SAT_HI = RB'((2 ** (apool_pkg::SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RB-1:0] SAT_LO = -SAT_HI - RB'(1);
  localparam logic signed [RB-1:0] HALF   = RB'(2 ** (apool_pkg::RECIP_FRAC - 1));

  logic signed [SUM_BITS-1:0] sums [DEPTH];

  logic                         s2_v_q;
  logic [AW-1:0]                s2_idx_q;
  apool_pkg::item_meta_t        s2_meta_q;
  logic signed [SUM_BITS-1:0]   rd_q;
  logic                         fw_v_q;
  logic [AW-1:0]                fw_idx_q;
  logic signed [SUM_BITS-1:0]   fw_sum_q;

  logic                         s3_v_q;
  logic signed [SUM_BITS-1:0]   s3_sum_q;
  apool_pkg::item_meta_t        s3_meta_q;

  logic                         s4_v_q;
  logic signed [PROD_BITS-1:0]  prod_q;
  apool_pkg::item_meta_t        s4_meta_q;

  logic                                 out_v_q;
  logic signed [apool_pkg::SAMPLE_BITS-1:0] avg_q;
  apool_pkg::item_meta_t                out_meta_q;

  logic                         out_rdy, s4_rdy, s3_rdy, s2_go;
  logic signed [SUM_BITS-1:0]   base, sum;
  logic signed [PROD_BITS-1:0]  prod_d;
  logic signed [RB-1:0]         rnd, shifted;
  logic signed [apool_pkg::SAMPLE_BITS-1:0] avg_d;

  assign out_rdy = !out_v_q || avg_out.ready;
  assign s4_rdy  = !s4_v_q || out_rdy;
  assign s3_rdy  = !s3_v_q || s4_rdy;
  assign s2_go   = s2_v_q && (!s2_meta_q.emit || s3_rdy);
  assign q_pop_o = q_valid_i && (!s2_v_q || s2_go);

  assign base = (fw_v_q && (fw_idx_q == s2_idx_q)) ? fw_sum_q : rd_q;
  assign sum  = s2_meta_q.first ? SUM_BITS'(s2_meta_q.sample)
                                : base + SUM_BITS'(s2_meta_q.sample);

  assign prod_d = PROD_BITS'(s3_sum_q) * PROD_BITS'($signed({1'b0, recip_i}));

  assign rnd     = RB'(prod_q) + HALF;
  assign shifted = rnd >>> apool_pkg::RECIP_FRAC;

  always_comb begin
    if (shifted > SAT_HI) begin
      avg_d = apool_pkg::SAMPLE_BITS'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      avg_d = apool_pkg::SAMPLE_BITS'(SAT_LO);
    end else begin
      avg_d = apool_pkg::SAMPLE_BITS'(shifted);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rd_q <= sums[q_idx_i];
    end
    if (s2_go) begin
      sums[s2_idx_q] <= sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s2_idx_q  <= q_idx_i;
      s2_meta_q <= q_meta_i;
    end
    if (s2_go) begin
      fw_idx_q <= s2_idx_q;
      fw_sum_q <= sum;
    end
    if (s2_go && s2_meta_q.emit) begin
      s3_sum_q  <= sum;
      s3_meta_q <= s2_meta_q;
    end
    if (s3_v_q && s4_rdy) begin
      prod_q    <= prod_d;
      s4_meta_q <= s3_meta_q;
    end
    if (s4_v_q && out_rdy) begin
      avg_q      <= avg_d;
      out_meta_q <= s4_meta_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      fw_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        s2_v_q <= 1'b1;
      end else if (s2_go) begin
        s2_v_q <= 1'b0;
      end
      if (s2_go) begin
        fw_v_q <= 1'b1;
      end
      if (s2_go && s2_meta_q.emit) begin
        s3_v_q <= 1'b1;
      end else if (s4_rdy) begin
        s3_v_q <= 1'b0;
      end
      if (s3_v_q && s4_rdy) begin
        s4_v_q <= 1'b1;
      end else if (out_rdy) begin
        s4_v_q <= 1'b0;
      end
      if (s4_v_q && out_rdy) begin
        out_v_q <= 1'b1;
      end else if (avg_out.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign avg_out.valid      = out_v_q;
  assign avg_out.average    = avg_q;
  assign avg_out.out_row    = out_meta_q.out_row;
  assign avg_out.out_column = out_meta_q.out_col;
  assign avg_out.channel    = out_meta_q.chan;
  assign avg_out.frame_end  = out_meta_q.last;

endmodule

// ===== hdl/average_pooling_2d_unit.sv =====
// Non-overlapping 2-D average pooling over a channel-interleaved sample raster.
//
// Samples enter on pix_in in row, column, channel order; frame_start on a
// sample restarts the raster at row 0, column 0, channel 0. Every sample that
// completes a window produces one transaction on avg_out carrying the rounded,
// saturated mean and its output row, column and channel; frame_end marks the
// last result of a frame. Samples in partial edge windows produce nothing.
// Configuration registers are written through cfg_we_i, cfg_index_i and cfg_data_i;
// the user must do so only while no transaction is in flight, which the block does
// not enforce. Throughput is one sample per cycle while avg_out does not stall, set
// by the single read-modify-write of the partial sum store per sample. After its last
// sample is accepted, a result passes through the queue, store read, accumulate,
// multiply and round steps. When avg_out stalls, the result register, the pipeline
// stages and the four-entry queue fill in turn before pix_in.ready drops.
// Reset clears all position counters and pipeline valid flags and loads the
// register defaults; the partial sum store needs no clearing because every
// window starts by overwriting its entry.
module average_pooling_2d_unit #(
  parameter int MAX_WIDTH    = apool_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = apool_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_WINDOW   = apool_pkg::DEF_MAX_WINDOW
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [apool_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [apool_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  apool_in_if.sink                             pix_in,
  apool_out_if.source                          avg_out
);

  localparam int DEPTH    = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW       = $clog2(DEPTH);
  localparam int SUM_BITS = apool_pkg::SAMPLE_BITS + 2 * $clog2(MAX_WINDOW);
  localparam int META_W   = $bits(apool_pkg::item_meta_t);

  localparam logic [apool_pkg::WIDTH_BITS-1:0] W_CAP =
    apool_pkg::WIDTH_BITS'((MAX_WIDTH < 2047) ? MAX_WIDTH : 2047);
  localparam logic [apool_pkg::HEIGHT_BITS-1:0] H_CAP =
    apool_pkg::HEIGHT_BITS'(apool_pkg::HEIGHT_LIMIT);
  localparam logic [apool_pkg::CHANS_BITS-1:0] C_CAP =
    apool_pkg::CHANS_BITS'((MAX_CHANNELS < 31) ? MAX_CHANNELS : 31);
  localparam logic [apool_pkg::WIN_BITS-1:0] WIN_CAP =
    apool_pkg::WIN_BITS'((MAX_WINDOW < 15) ? MAX_WINDOW : 15);

  apool_pkg::cfg_t       raw_q, eff;
  logic                  push, q_full, q_pop, q_valid;
  logic [AW-1:0]         push_idx, q_idx;
  apool_pkg::item_meta_t push_meta, q_meta;
  logic [AW+META_W-1:0]  q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q.width  <= apool_pkg::RST_IMAGE_WIDTH;
      raw_q.height <= apool_pkg::RST_IMAGE_HEIGHT;
      raw_q.chans  <= apool_pkg::RST_CHANNELS;
      raw_q.win_h  <= apool_pkg::RST_WIN_H;
      raw_q.win_w  <= apool_pkg::RST_WIN_W;
      raw_q.recip  <= apool_pkg::RST_RECIP;
    end else if (cfg_we_i) begin
      case (apool_pkg::cfg_index_e'(cfg_index_i))
        apool_pkg::CFG_IMAGE_WIDTH: begin
          raw_q.width <= apool_pkg::WIDTH_BITS'(cfg_data_i);
        end
        apool_pkg::CFG_IMAGE_HEIGHT: begin
          raw_q.height <= apool_pkg::HEIGHT_BITS'(cfg_data_i);
        end
        apool_pkg::CFG_CHANNEL_COUNT: begin
          raw_q.chans <= apool_pkg::CHANS_BITS'(cfg_data_i);
        end
        apool_pkg::CFG_WINDOW_HEIGHT: begin
          raw_q.win_h <= apool_pkg::WIN_BITS'(cfg_data_i);
        end
        apool_pkg::CFG_WINDOW_WIDTH: begin
          raw_q.win_w <= apool_pkg::WIN_BITS'(cfg_data_i);
        end
        apool_pkg::CFG_AREA_RECIPROCAL: begin
          raw_q.recip <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    eff.width  = (raw_q.width == '0) ? apool_pkg::WIDTH_BITS'(1)
               : (raw_q.width > W_CAP) ? W_CAP : raw_q.width;
    eff.height = (raw_q.height == '0) ? apool_pkg::HEIGHT_BITS'(1)
               : (raw_q.height > H_CAP) ? H_CAP : raw_q.height;
    eff.chans  = (raw_q.chans == '0) ? apool_pkg::CHANS_BITS'(1)
               : (raw_q.chans > C_CAP) ? C_CAP : raw_q.chans;
    eff.win_h  = (raw_q.win_h == '0) ? apool_pkg::WIN_BITS'(1)
               : (raw_q.win_h > WIN_CAP) ? WIN_CAP : raw_q.win_h;
    eff.win_w  = (raw_q.win_w == '0) ? apool_pkg::WIN_BITS'(1)
               : (raw_q.win_w > WIN_CAP) ? WIN_CAP : raw_q.win_w;
    eff.recip  = raw_q.recip;
  end

  apool_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_WINDOW   (MAX_WINDOW),
    .AW           (AW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (eff),
    .pix_in   (pix_in),
    .q_full_i (q_full),
    .push_o   (push),
    .idx_o    (push_idx),
    .meta_o   (push_meta)
  );

  apool_fifo #(
    .DATA_W (AW + META_W),
    .DEPTH  (apool_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_idx, push_meta}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  assign q_idx  = q_head[AW+META_W-1:META_W];
  assign q_meta = apool_pkg::item_meta_t'(q_head[META_W-1:0]);

  apool_back #(
    .AW       (AW),
    .DEPTH    (DEPTH),
    .SUM_BITS (SUM_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .recip_i   (eff.recip),
    .q_valid_i (q_valid),
    .q_idx_i   (q_idx),
    .q_meta_i  (q_meta),
    .q_pop_o   (q_pop),
    .avg_out   (avg_out)
  );

endmodule

// ===== hdl/apool_checker.sv =====
// Port-level assertions for the average pooling unit and their binding to the top level.
module apool_checker (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  input  logic                                     in_ready_i,
  input  logic                                     out_valid_i,
  input  logic                                     out_ready_i,
  input  logic signed [apool_pkg::SAMPLE_BITS-1:0] out_average_i,
  input  logic [apool_pkg::COORD_BITS-1:0]         out_row_i,
  input  logic [apool_pkg::COORD_BITS-1:0]         out_column_i,
  input  logic [apool_pkg::CHAN_BITS-1:0]          out_channel_i,
  input  logic                                     out_frame_end_i
);

  logic [31:0] in_cnt_q, out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        in_cnt_q <= in_cnt_q + 32'd1;
      end
      if (out_valid_i && out_ready_i) begin
        out_cnt_q <= out_cnt_q + 32'd1;
      end
    end
  end

  // A result transaction must never outnumber the sample transactions before it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |-> in_cnt_q > out_cnt_q)
    else $error("result transaction without a preceding sample transaction");

  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_average_i) && $stable(out_row_i)
      && $stable(out_column_i) && $stable(out_channel_i) && $stable(out_frame_end_i))
    else $error("result payload changed while stalled");

endmodule

bind average_pooling_2d_unit apool_checker u_apool_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (pix_in.valid),
  .in_ready_i      (pix_in.ready),
  .out_valid_i     (avg_out.valid),
  .out_ready_i     (avg_out.ready),
  .out_average_i   (avg_out.average),
  .out_row_i       (avg_out.out_row),
  .out_column_i    (avg_out.out_column),
  .out_channel_i   (avg_out.channel),
  .out_frame_end_i (avg_out.frame_end)
);
